// ===== rtl/core/icpm_pkg.sv =====
// shared constants, types and functions of the iteration count palette mapper
package icpm_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int T_W         = FRAC_BITS + 1;
    localparam int COUNT_W     = 16;
    localparam int NUM_W       = COUNT_W + FRAC_BITS;
    localparam int DIV_STEPS   = T_W;
    localparam int SQ_STEPS    = T_W;
    localparam int SQ_BITS_W   = 2 * SQ_STEPS;
    localparam int SQ_REM_W    = T_W + 2;
    localparam int WAVE_DEPTH  = 1024;
    localparam int WAVE_IDX_W  = $clog2(WAVE_DEPTH);
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [1:0] MODE_FIRE    = 2'd0;
    localparam logic [1:0] MODE_STRIPES = 2'd1;
    localparam logic [1:0] MODE_SMOOTH  = 2'd2;
    localparam logic [1:0] MODE_CLASSIC = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_MODE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_LIMIT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RED   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GREEN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BLUE  = 3'd4;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] Q30_PI      = 64'd3373259426;
    localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
    localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
    localparam logic [63:0] SINE_DIV [6] = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    typedef logic [7:0] wave_t [WAVE_DEPTH];

    // grey level table for one sine period, built at elaboration
    function automatic wave_t build_wave();
        wave_t w;
        logic [63:0] a;
        logic [63:0] sq;
        logic [63:0] h;
        logic [63:0] s;
        logic [63:0] level;
        logic neg;
        for (int k = 0; k < WAVE_DEPTH; k++)
        begin
            a = (64'(k) * Q30_TWO_PI) / WAVE_DEPTH;
            neg = 1'b0;
            if (a > Q30_PI)
            begin
                neg = 1'b1;
                a = a - Q30_PI;
            end
            if (a > Q30_HALF_PI)
                a = Q30_PI - a;
            sq = (a * a) >> 30;
            h = Q30_ONE;
            for (int i = 0; i < 6; i++)
                h = Q30_ONE - ((sq * h) >> 30) / SINE_DIV[i];
            s = (a * h) >> 30;
            if (s > Q30_ONE)
                s = Q30_ONE;
            level = (64'd255 * (neg ? Q30_ONE - s : Q30_ONE + s)) >> 31;
            w[k] = (level > 64'd255) ? 8'hff : level[7:0];
        end
        return w;
    endfunction

    // floor(x / 255) for x below 65280
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return s[15:8];
    endfunction

    function automatic logic [7:0] clamp8(input logic [12:0] x);
        return (x > 13'd255) ? 8'hff : x[7:0];
    endfunction

endpackage

// ===== rtl/core/icpm_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module icpm_div
    import icpm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [NUM_W-1:0]     in_num,
    input  logic                 in_eq,
    input  logic [COUNT_W-1:0]   lim,
    output logic                 out_valid,
    output logic [T_W-1:0]       out_quo,
    output logic                 out_eq
);

    logic               vld_reg [DIV_STEPS+1];
    logic               eq_reg  [DIV_STEPS+1];
    logic [COUNT_W-1:0] rem_reg [DIV_STEPS+1];
    logic [T_W-1:0]     low_reg [DIV_STEPS+1];
    logic [T_W-1:0]     quo_reg [DIV_STEPS+1];

    logic [T_W-1:0]     trial   [DIV_STEPS+1];
    logic               ge      [DIV_STEPS+1];
    logic [COUNT_W-1:0] rem_next[DIV_STEPS+1];

    always_comb
    begin
        for (int k = 0; k <= DIV_STEPS; k++)
        begin
            trial[k]    = '0;
            ge[k]       = 1'b0;
            rem_next[k] = '0;
        end
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            trial[k] = {rem_reg[k-1], low_reg[k-1][T_W-1]};
            ge[k]    = trial[k] >= {1'b0, lim};
            rem_next[k] = ge[k] ? COUNT_W'(trial[k] - {1'b0, lim}) : trial[k][COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= DIV_STEPS; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // quotient fits in T_W bits, so the top bits start as remainder
            rem_reg[0] <= {1'b0, in_num[NUM_W-1:T_W]};
            low_reg[0] <= in_num[T_W-1:0];
            quo_reg[0] <= '0;
            eq_reg[0]  <= in_eq;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= {low_reg[k-1][T_W-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][T_W-2:0], ge[k]};
                eq_reg[k]  <= eq_reg[k-1];
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS];
    assign out_quo   = quo_reg[DIV_STEPS];
    assign out_eq    = eq_reg[DIV_STEPS];

endmodule

// ===== rtl/core/icpm_sqrt.sv =====
// pipelined digit-by-digit square root of t scaled by 2^16
module icpm_sqrt
    import icpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [T_W-1:0]   in_t,
    input  logic             in_eq,
    output logic             out_valid,
    output logic [T_W-1:0]   out_t,
    output logic [T_W-1:0]   out_root,
    output logic             out_eq
);

    logic                 vld_reg  [SQ_STEPS];
    logic                 eq_reg   [SQ_STEPS];
    logic [T_W-1:0]       t_reg    [SQ_STEPS];
    logic [SQ_REM_W-1:0]  rem_reg  [SQ_STEPS];
    logic [T_W-1:0]       root_reg [SQ_STEPS];
    logic [SQ_BITS_W-1:0] bits_reg [SQ_STEPS];

    logic [SQ_REM_W-1:0]  rem_in   [SQ_STEPS];
    logic [T_W-1:0]       root_in  [SQ_STEPS];
    logic [SQ_BITS_W-1:0] bits_in  [SQ_STEPS];
    logic [SQ_REM_W+1:0]  part     [SQ_STEPS];
    logic [SQ_REM_W+1:0]  test     [SQ_STEPS];
    logic                 ge       [SQ_STEPS];

    always_comb
    begin
        for (int k = 0; k < SQ_STEPS; k++)
        begin
            if (k == 0)
            begin
                rem_in[k]  = '0;
                root_in[k] = '0;
                bits_in[k] = SQ_BITS_W'({in_t, {FRAC_BITS{1'b0}}});
            end
            else
            begin
                rem_in[k]  = rem_reg[k-1];
                root_in[k] = root_reg[k-1];
                bits_in[k] = bits_reg[k-1];
            end
            part[k] = {rem_in[k], bits_in[k][SQ_BITS_W-1:SQ_BITS_W-2]};
            test[k] = (SQ_REM_W+2)'({root_in[k], 2'b01});
            ge[k]   = part[k] >= test[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQ_STEPS; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < SQ_STEPS; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQ_STEPS; k++)
            begin
                rem_reg[k]  <= ge[k] ? SQ_REM_W'(part[k] - test[k]) : SQ_REM_W'(part[k]);
                root_reg[k] <= {root_in[k][T_W-2:0], ge[k]};
                bits_reg[k] <= {bits_in[k][SQ_BITS_W-3:0], 2'b00};
                t_reg[k]    <= (k == 0) ? in_t : t_reg[k == 0 ? 0 : k-1];
                eq_reg[k]   <= (k == 0) ? in_eq : eq_reg[k == 0 ? 0 : k-1];
            end
        end
    end

    assign out_valid = vld_reg[SQ_STEPS-1];
    assign out_t     = t_reg[SQ_STEPS-1];
    assign out_root  = root_reg[SQ_STEPS-1];
    assign out_eq    = eq_reg[SQ_STEPS-1];

endmodule

// ===== rtl/core/icpm_shade.sv =====
// palette arithmetic: power chain, polynomials, sine table and channel select
module icpm_shade
    import icpm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic [1:0]     mode,
    input  logic [7:0]     base_r,
    input  logic [7:0]     base_g,
    input  logic [7:0]     base_b,
    input  logic           in_valid,
    input  logic [T_W-1:0] in_t,
    input  logic [T_W-1:0] in_root,
    input  logic           in_eq,
    output logic           out_valid,
    output logic [7:0]     out_r,
    output logic [7:0]     out_g,
    output logic [7:0]     out_b
);

    localparam wave_t WAVE_ROM = build_wave();

    logic [5:0] vld_reg;

    // stage 1
    logic [T_W-1:0] t1_reg, u1_reg, t15_1_reg, t2_1_reg, u2_1_reg, ut1_reg;
    logic [7:0]     q1_reg, wave1_reg;
    logic           eq1_reg;
    // stage 2
    logic [T_W-1:0] t2s_reg, t15_2_reg, t3_2_reg, r1_2_reg, g1_2_reg, u3_2_reg;
    logic [7:0]     q2_reg, wave2_reg;
    logic           eq2_reg;
    // stage 3
    logic [T_W-1:0] t45_3_reg, r1_3_reg, g1_3_reg, b1_3_reg;
    logic [8:0]     fr_raw3_reg, fg_raw3_reg;
    logic [7:0]     q3_reg, wave3_reg;
    logic           eq3_reg;
    // stage 4
    logic [16:0]    fr_p4_reg, fg_p4_reg;
    logic [8:0]     fb_raw4_reg;
    logic [7:0]     sr4_reg, sg4_reg, sb4_reg, q4_reg, wave4_reg;
    logic           eq4_reg;
    // stage 5
    logic [16:0]    fb_p5_reg;
    logic [7:0]     fr5_reg, fg5_reg, sr5_reg, sg5_reg, sb5_reg, q5_reg, wave5_reg;
    logic           eq5_reg;
    // output
    logic [7:0]     r_reg, g_reg, b_reg;

    logic [2*T_W-1:0] m_t15, m_t2, m_u2, m_ut, m_t3, m_r1, m_g1, m_u3, m_t45, m_b1;
    logic [T_W-1:0]   u_next;
    logic [T_W+2:0]   t5;
    logic [T_W+7:0]   m_fr, m_fg, m_fb;
    logic [28:0]      m_sr, m_sg;
    logic [29:0]      m_sb;
    logic [7:0]       r_next, g_next, b_next;
    logic [7:0]       fb_next;

    always_comb
    begin
        u_next = T_W'({1'b1, {FRAC_BITS{1'b0}}} - in_t);
        t5     = (T_W+3)'(in_t) * (T_W+3)'(5);
        m_t15  = (2*T_W)'(in_t) * (2*T_W)'(in_root);
        m_t2   = (2*T_W)'(in_t) * (2*T_W)'(in_t);
        m_u2   = (2*T_W)'(u_next) * (2*T_W)'(u_next);
        m_ut   = (2*T_W)'(u_next) * (2*T_W)'(in_t);
        m_t3   = (2*T_W)'(t15_1_reg) * (2*T_W)'(t15_1_reg);
        m_r1   = (2*T_W)'(ut1_reg) * (2*T_W)'(t2_1_reg);
        m_g1   = (2*T_W)'(u2_1_reg) * (2*T_W)'(t2_1_reg);
        m_u3   = (2*T_W)'(u2_1_reg) * (2*T_W)'(u1_reg);
        m_t45  = (2*T_W)'(t3_2_reg) * (2*T_W)'(t15_2_reg);
        m_b1   = (2*T_W)'(u3_2_reg) * (2*T_W)'(t2s_reg);
        m_fr   = (T_W+8)'(t15_2_reg) * (T_W+8)'(255);
        m_fg   = (T_W+8)'(t3_2_reg) * (T_W+8)'(255);
        m_fb   = (T_W+8)'(t45_3_reg) * (T_W+8)'(255);
        m_sr   = 29'(r1_3_reg) * 29'(2295);
        m_sg   = 29'(g1_3_reg) * 29'(3825);
        m_sb   = 30'(b1_3_reg) * 30'(4335);
        fb_next = fb_p5_reg[16] ? 8'hff : div255(fb_p5_reg[15:0]);

        case (mode)
            MODE_FIRE:
            begin
                r_next = eq5_reg ? 8'd0 : fr5_reg;
                g_next = eq5_reg ? 8'd0 : fg5_reg;
                b_next = eq5_reg ? 8'd0 : fb_next;
            end
            MODE_STRIPES:
            begin
                r_next = wave5_reg;
                g_next = wave5_reg;
                b_next = wave5_reg;
            end
            MODE_SMOOTH:
            begin
                r_next = sr5_reg;
                g_next = sg5_reg;
                b_next = sb5_reg;
            end
            default:
            begin
                r_next = q5_reg;
                g_next = q5_reg;
                b_next = q5_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[4:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg    <= in_t;
            u1_reg    <= u_next;
            t15_1_reg <= m_t15[FRAC_BITS +: T_W];
            t2_1_reg  <= m_t2[FRAC_BITS +: T_W];
            u2_1_reg  <= m_u2[FRAC_BITS +: T_W];
            ut1_reg   <= m_ut[FRAC_BITS +: T_W];
            q1_reg    <= in_t[7:0];
            // stripe index is floor(5 * depth * t) modulo depth
            wave1_reg <= WAVE_ROM[t5[FRAC_BITS-1 -: WAVE_IDX_W]];
            eq1_reg   <= in_eq;

            t2s_reg   <= t1_reg;
            t15_2_reg <= t15_1_reg;
            t3_2_reg  <= m_t3[FRAC_BITS +: T_W];
            r1_2_reg  <= m_r1[FRAC_BITS +: T_W];
            g1_2_reg  <= m_g1[FRAC_BITS +: T_W];
            u3_2_reg  <= m_u3[FRAC_BITS +: T_W];
            q2_reg    <= q1_reg;
            wave2_reg <= wave1_reg;
            eq2_reg   <= eq1_reg;

            t45_3_reg   <= m_t45[FRAC_BITS +: T_W];
            r1_3_reg    <= r1_2_reg;
            g1_3_reg    <= g1_2_reg;
            b1_3_reg    <= m_b1[FRAC_BITS +: T_W];
            fr_raw3_reg <= m_fr[FRAC_BITS +: 9];
            fg_raw3_reg <= m_fg[FRAC_BITS +: 9];
            q3_reg      <= q2_reg;
            wave3_reg   <= wave2_reg;
            eq3_reg     <= eq2_reg;

            fr_p4_reg   <= 17'(fr_raw3_reg) * 17'(base_r);
            fg_p4_reg   <= 17'(fg_raw3_reg) * 17'(base_g);
            fb_raw4_reg <= m_fb[FRAC_BITS +: 9];
            sr4_reg     <= clamp8(m_sr[FRAC_BITS +: 13]);
            sg4_reg     <= clamp8(m_sg[FRAC_BITS +: 13]);
            sb4_reg     <= clamp8(m_sb[FRAC_BITS+1 +: 13]);
            q4_reg      <= q3_reg;
            wave4_reg   <= wave3_reg;
            eq4_reg     <= eq3_reg;

            fb_p5_reg <= 17'(fb_raw4_reg) * 17'(base_b);
            fr5_reg   <= fr_p4_reg[16] ? 8'hff : div255(fr_p4_reg[15:0]);
            fg5_reg   <= fg_p4_reg[16] ? 8'hff : div255(fg_p4_reg[15:0]);
            sr5_reg   <= sr4_reg;
            sg5_reg   <= sg4_reg;
            sb5_reg   <= sb4_reg;
            q5_reg    <= q4_reg;
            wave5_reg <= wave4_reg;
            eq5_reg   <= eq4_reg;

            r_reg <= r_next;
            g_reg <= g_next;
            b_reg <= b_next;
        end
    end

    assign out_valid = vld_reg[5];
    assign out_r     = r_reg;
    assign out_g     = g_reg;
    assign out_b     = b_reg;

endmodule

// ===== rtl/core/iteration_count_palette_mapper.sv =====
// top level of the iteration count palette mapper
// data flows through the divider, root and palette pipelines in that order
// throughput: one word per cycle; the whole pipeline moves together and holds
// while the output word waits, so nothing is lost or repeated on a stall
// reset clears all valid bits and loads the register defaults:
// fire palette, limit 100, base colors 255
module iteration_count_palette_mapper
    import icpm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] iteration_count
    // output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    logic [1:0]         mode_reg;
    logic [COUNT_W-1:0] limit_reg;
    logic [7:0]         base_r_reg, base_g_reg, base_b_reg;

    logic               en;
    logic [COUNT_W-1:0] lim;
    logic [COUNT_W-1:0] cnt;
    logic [NUM_W-1:0]   num;
    logic               cnt_eq;

    logic               div_valid, div_eq;
    logic [T_W-1:0]     div_quo;
    logic               sq_valid, sq_eq;
    logic [T_W-1:0]     sq_t, sq_root;
    logic [7:0]         red, green, blue;

    // config registers; the user must write them only while the pipeline is empty, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_FIRE;
            limit_reg  <= 16'd100;
            base_r_reg <= 8'd255;
            base_g_reg <= 8'd255;
            base_b_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MODE:  mode_reg   <= cfg_data[1:0];
                REG_LIMIT: limit_reg  <= cfg_data;
                REG_RED:   base_r_reg <= cfg_data[7:0];
                REG_GREEN: base_g_reg <= cfg_data[7:0];
                REG_BLUE:  base_b_reg <= cfg_data[7:0];
                default:   ;
            endcase
        end
    end

    // global advance: hold everything while the output word is not taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // a zero limit acts as one; counts above the limit saturate
    always_comb
    begin
        lim    = (limit_reg == '0) ? COUNT_W'(1) : limit_reg;
        cnt    = (s_tdata > lim) ? lim : s_tdata;
        cnt_eq = cnt == lim;
        // classic ramp divides count * 255, every other palette divides count << 16
        if (mode_reg == MODE_CLASSIC)
            num = NUM_W'({cnt, 8'd0} - {8'd0, cnt});
        else
            num = {cnt, {FRAC_BITS{1'b0}}};
    end

    icpm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_num    (num),
        .in_eq     (cnt_eq),
        .lim       (lim),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_eq    (div_eq)
    );

    icpm_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_t      (div_quo),
        .in_eq     (div_eq),
        .out_valid (sq_valid),
        .out_t     (sq_t),
        .out_root  (sq_root),
        .out_eq    (sq_eq)
    );

    icpm_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .mode      (mode_reg),
        .base_r    (base_r_reg),
        .base_g    (base_g_reg),
        .base_b    (base_b_reg),
        .in_valid  (sq_valid),
        .in_t      (sq_t),
        .in_root   (sq_root),
        .in_eq     (sq_eq),
        .out_valid (m_tvalid),
        .out_r     (red),
        .out_g     (green),
        .out_b     (blue)
    );

    assign m_tdata = {blue, green, red};

endmodule
